@@ rtl/smpq_pkg.sv @@
// ----------------------------------------------------------------------------
// smpq_pkg
// Types and codes shared by the sorted minimum priority queue modules.
// ----------------------------------------------------------------------------
package smpq_pkg;

    localparam int PRICE_W = 24;
    localparam int TOTAL_W = 28;
    localparam int OTAG_W  = 16;
    localparam int COUNT_W = 5;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2
    } t_err;

    typedef struct packed {
        logic                op;
        logic [OTAG_W-1:0]   item_tag;
        logic [PRICE_W-1:0]  price;
    } t_in;

    typedef struct packed {
        logic                head_valid;
        logic [OTAG_W-1:0]   head_tag;
        logic [PRICE_W-1:0]  head_price;
        logic [COUNT_W-1:0]  entry_count;
        logic [TOTAL_W-1:0]  price_total;
        logic [1:0]          error_code;
    } t_out;

    typedef struct packed {
        logic push;
        logic pop;
    } t_step;

    typedef struct packed {
        logic                valid;
        logic [PRICE_W-1:0]  price;
        logic                ins;
    } t_link;

endpackage

@@ rtl/sorted_min_priority_queue_top.sv @@
// ----------------------------------------------------------------------------
// sorted_min_priority_queue_top
// Bounded minimum priority queue kept in ascending price order in a row of
// slot cells, with entry count and running price total.
//
//   Channel   Ports                  Transfer
//   command   start, busy, i_cmd     start high while busy low
//   result    o_done, o_result       o_done high, one cycle, no stall
//
// One command is taken in every cycle; busy stays low.
// Its result appears on the cycle after the transfer, for one cycle.
// All cells decide their move in parallel from one compare each.
// Synchronous reset empties the queue and clears the total.
// The receiver cannot stall results.
// ----------------------------------------------------------------------------
module sorted_min_priority_queue_top
    import smpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_cmd,
    output logic o_done,
    output t_out o_result
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_link                w_link [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]  w_tag  [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_valid;
    logic [TAG_BITS-1:0]  w_new_tag;
    logic [OTAG_W-1:0]    w_head_tag;
    logic [COUNT_W-1:0]   w_count_out;
    logic                 w_accept;
    logic                 w_full;
    logic                 w_empty;
    t_step                w_step;
    t_err                 w_err;

    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic [TOTAL_W-1:0]   r_total;
    logic [TOTAL_W-1:0]   n_total;
    t_err                 r_err;
    logic                 r_done;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_full   = w_link[QUEUE_DEPTH-1].valid;
    assign w_empty  = !w_link[0].valid;

    generate
        if (TAG_BITS >= OTAG_W) begin : g_tag_wide
            assign w_new_tag  = TAG_BITS'(i_cmd.item_tag);
            assign w_head_tag = w_tag[0][OTAG_W-1:0];
        end else begin : g_tag_narrow
            assign w_new_tag  = i_cmd.item_tag[TAG_BITS-1:0];
            assign w_head_tag = {{(OTAG_W - TAG_BITS){1'b0}}, w_tag[0]};
        end
        if (CW >= COUNT_W) begin : g_cnt_wide
            assign w_count_out = r_count[COUNT_W-1:0];
        end else begin : g_cnt_narrow
            assign w_count_out = {{(COUNT_W - CW){1'b0}}, r_count};
        end
    endgenerate

    always_comb begin
        w_step.push = 1'b0;
        w_step.pop  = 1'b0;
        w_err       = ERR_OK;
        if (w_accept) begin
            case (t_op'(i_cmd.op))
                OP_PUSH: begin
                    if (w_full) begin
                        w_err = ERR_FULL;
                    end else begin
                        w_step.push = 1'b1;
                    end
                end
                OP_POP: begin
                    if (w_empty) begin
                        w_err = ERR_EMPTY;
                    end else begin
                        w_step.pop = 1'b1;
                    end
                end
                default: begin
                    w_err = ERR_OK;
                end
            endcase
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            t_link               w_left;
            logic [TAG_BITS-1:0] w_left_tag;
            t_link               w_right;
            logic [TAG_BITS-1:0] w_right_tag;

            if (gi == 0) begin : g_first
                assign w_left     = '0;
                assign w_left_tag = '0;
            end else begin : g_mid_l
                assign w_left     = w_link[gi-1];
                assign w_left_tag = w_tag[gi-1];
            end
            if (gi == QUEUE_DEPTH - 1) begin : g_last
                assign w_right     = '0;
                assign w_right_tag = '0;
            end else begin : g_mid_r
                assign w_right     = w_link[gi+1];
                assign w_right_tag = w_tag[gi+1];
            end

            smpq_cell #(
                .TAG_BITS (TAG_BITS)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_step      (w_step),
                .i_strict    (gi == 0),
                .i_new_price (i_cmd.price),
                .i_new_tag   (w_new_tag),
                .i_left      (w_left),
                .i_left_tag  (w_left_tag),
                .i_right     (w_right),
                .i_right_tag (w_right_tag),
                .o_link      (w_link[gi]),
                .o_tag       (w_tag[gi])
            );

            assign w_valid[gi] = w_link[gi].valid;
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        n_total = r_total;
        if (w_step.push) begin
            n_count = r_count + CW'(1);
            n_total = r_total + TOTAL_W'(i_cmd.price);
        end else if (w_step.pop) begin
            n_count = r_count - CW'(1);
            n_total = r_total - TOTAL_W'(w_link[0].price);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_total <= '0;
            r_err   <= ERR_OK;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_total <= n_total;
            r_err   <= w_err;
            r_done  <= w_accept;
        end
    end

    assign o_done                = r_done;
    assign o_result.head_valid   = w_link[0].valid;
    assign o_result.head_tag     = w_link[0].valid ? w_head_tag : '0;
    assign o_result.head_price   = w_link[0].valid ? w_link[0].price : '0;
    assign o_result.entry_count  = w_count_out;
    assign o_result.price_total  = r_total;
    assign o_result.error_code   = r_err;

    // The occupied slots always form a prefix whose length is the count.
    a_valid_prefix : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid == QUEUE_DEPTH'((({{QUEUE_DEPTH{1'b0}}, 1'b1}) << r_count) - 1'b1))
        else $error("slot valid bits disagree with entry count");

    a_head_order : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_link[1].valid |-> (w_link[0].price <= w_link[1].price))
        else $error("head entry is not the smallest");

    a_done_follows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_done)
        else $error("accepted command produced no result");

    a_no_spurious : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> !o_done)
        else $error("result without a command");

    a_full_drop : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_cmd.op == OP_PUSH) && w_full) |=>
            ($stable(r_count) && $stable(r_total) && (r_err == ERR_FULL)))
        else $error("push to full queue changed the state");

endmodule

@@ rtl/smpq_cell.sv @@
// ----------------------------------------------------------------------------
// smpq_cell
// One slot of the sorted queue. On a push it keeps its entry, takes the new
// entry or takes its left neighbor; on a pop it takes its right neighbor.
// ----------------------------------------------------------------------------
module smpq_cell
    import smpq_pkg::*;
#(
    parameter int TAG_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_step               i_step,
    input  logic                i_strict,
    input  logic [PRICE_W-1:0]  i_new_price,
    input  logic [TAG_BITS-1:0] i_new_tag,
    input  t_link               i_left,
    input  logic [TAG_BITS-1:0] i_left_tag,
    input  t_link               i_right,
    input  logic [TAG_BITS-1:0] i_right_tag,
    output t_link               o_link,
    output logic [TAG_BITS-1:0] o_tag
);

    logic                r_valid;
    logic [PRICE_W-1:0]  r_price;
    logic [TAG_BITS-1:0] r_tag;
    logic                n_valid;
    logic [PRICE_W-1:0]  n_price;
    logic [TAG_BITS-1:0] n_tag;
    logic                w_cmp;
    logic                w_ins;

    assign w_cmp = i_strict ? (i_new_price < r_price) : (r_price >= i_new_price);
    assign w_ins = !r_valid || w_cmp;

    always_comb begin
        n_valid = r_valid;
        n_price = r_price;
        n_tag   = r_tag;
        if (i_step.pop) begin
            n_valid = i_right.valid;
            n_price = i_right.price;
            n_tag   = i_right_tag;
        end else if (i_step.push && w_ins) begin
            if (i_left.ins) begin
                n_valid = i_left.valid;
                n_price = i_left.price;
                n_tag   = i_left_tag;
            end else begin
                n_valid = 1'b1;
                n_price = i_new_price;
                n_tag   = i_new_tag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_price <= n_price;
        r_tag   <= n_tag;
    end

    assign o_link = '{valid: r_valid, price: r_price, ins: w_ins};
    assign o_tag  = r_tag;

endmodule
